// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the rANS decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define RID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RID_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RID_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RID_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/rid_pkg.sv =====
// Package: constants, codes and types of the interleaved rANS decoder.
`default_nettype none
package rid_pkg;
  localparam int LANES       = 8;
  localparam int SCALE_BITS  = 12;

  localparam int SYMBOLS     = 256;
  localparam int SYM_W       = 8;
  localparam int SYM_IDX_W   = 9;
  localparam int CUM_W       = 24;
  localparam int FREQ_IN_W   = 16;
  localparam int STATE_W     = 64;
  localparam int WORD_W      = 32;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;

  localparam int M_TOTAL     = 1 << SCALE_BITS;
  localparam int SLOT_CNT_W  = SCALE_BITS + 1;
  localparam int FREQ_W      = SCALE_BITS + 1;
  localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int LANE_CNT_W  = $clog2(LANES + 1);
  localparam int HI_W        = STATE_W - SCALE_BITS;
  localparam int LO_W        = HI_W / 2;
  localparam int UP_W        = HI_W - LO_W;

  localparam logic [STATE_W-1:0] RENORM_LOW = STATE_W'(64'h8000_0000);

  localparam logic [OP_W-1:0] OP_BEGIN     = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_FREQ = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_LANE = 3'd2;
  localparam logic [OP_W-1:0] OP_DECODE    = 3'd3;
  localparam logic [OP_W-1:0] OP_FINISH    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_END   = 2'd3;

  typedef struct packed {
    logic [SCALE_BITS-1:0] freq_m1;
    logic [SCALE_BITS-1:0] offset;
    logic [SYM_W-1:0]      sym;
  } slot_entry_t;
endpackage
`default_nettype wire

// ===== rtl/rans_if.sv =====
// Valid/ready channel interfaces for the rANS decoder input and result words.
`default_nettype none
interface rans_in_if import rid_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [FREQ_IN_W-1:0] freq_value;
  logic [STATE_W-1:0]   lane_state;
  logic [WORD_W-1:0]    stream_word;
  logic                 word_present;

  modport source (output valid, op, freq_value, lane_state, stream_word, word_present,
                  input ready);
  modport sink   (input valid, op, freq_value, lane_state, stream_word, word_present,
                  output ready);
endinterface

interface rans_out_if import rid_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYM_W-1:0]    symbol;
  logic                word_used;
  logic [STATUS_W-1:0] status;

  modport source (output valid, symbol, word_used, status, input ready);
  modport sink   (input valid, symbol, word_used, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/rans_interleaved_decoder.sv =====
// Top level: interleaved order-0 rANS decoder with slot table and lane state memories.
//
//   channel   dir  handshake          word
//   in_ch     in   valid/ready        op, freq_value, lane_state, stream_word, word_present
//   out_ch    out  valid/ready        symbol, word_used, status
//
// One word in flight at a time; every input word yields one result word.
// Begin, lane load, finish and error passes go from accept straight to the result;
// decode steps through lane read, slot-table read, split multiply and update;
// a frequency word writing n table slots writes one slot per cycle.
// A waiting result is held in the output register; the next word is taken meanwhile.
// Reset clears control state only; table and lane memories are not cleared.
`default_nettype none
`include "assert_macros.svh"
module rans_interleaved_decoder import rid_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  rans_in_if.sink    in_ch,
  rans_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_SLOT = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [CUM_W-1:0]      cum_r, cum_nxt;
  logic [SYM_IDX_W-1:0]  sym_idx_r, sym_idx_nxt;
  logic [LANE_CNT_W-1:0] lane_idx_r, lane_idx_nxt;
  logic [LANE_W-1:0]     dec_lane_r, dec_lane_nxt;
  logic                  tv_r, tv_nxt;
  logic [STATUS_W-1:0]   err_r, err_nxt;
  logic [LANES-1:0]      at_low_r, at_low_nxt;

  logic [SLOT_CNT_W-1:0] fill_j_r, fill_j_nxt;
  logic [SLOT_CNT_W-1:0] fill_stop_r, fill_stop_nxt;
  logic [SCALE_BITS-1:0] fill_base_r, fill_base_nxt;
  logic [SCALE_BITS-1:0] fill_fm1_r, fill_fm1_nxt;
  logic [SYM_W-1:0]      fill_sym_r, fill_sym_nxt;

  logic [SYM_W-1:0]      res_sym_r, res_sym_nxt;
  logic                  res_used_r, res_used_nxt;

  // latched input word
  logic [OP_W-1:0]       op_r;
  logic [FREQ_IN_W-1:0]  fv_r;
  logic [STATE_W-1:0]    ls_r;
  logic [WORD_W-1:0]     word_r;
  logic                  present_r;

  // memories
  slot_entry_t           slot_mem [M_TOTAL];
  logic [STATE_W-1:0]    lane_mem [LANES];
  slot_entry_t           slot_q_r;
  logic [STATE_W-1:0]    lane_q_r;
  logic                  slot_we;
  logic [SCALE_BITS-1:0] slot_waddr;
  slot_entry_t           slot_wdata;
  logic                  lane_we;
  logic [LANE_W-1:0]     lane_waddr;
  logic [STATE_W-1:0]    lane_wdata;

  // decode datapath
  logic [FREQ_W+LO_W-1:0] p_lo_r;
  logic [FREQ_W+UP_W-1:0] p_up_r;
  logic [SCALE_BITS-1:0]  ofs_r;
  logic [SYM_W-1:0]       ent_sym_r;
  logic [FREQ_W-1:0]      dec_freq;
  logic [HI_W-1:0]        s_hi;
  logic [STATE_W-1:0]     t_val;
  logic                   take;
  logic [STATE_W-1:0]     t_new;

  logic                  out_valid_r;
  logic [SYM_W-1:0]      out_sym_r;
  logic                  out_used_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic                  out_free;
  logic                  lanes_ready;
  logic [CUM_W-1:0]      freq_end;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.symbol    = out_sym_r;
  assign out_ch.word_used = out_used_r;
  assign out_ch.status    = out_status_r;
  assign out_free         = !out_valid_r || out_ch.ready;
  assign lanes_ready      = tv_r && (lane_idx_r >= LANE_CNT_W'(LANES));
  assign freq_end         = cum_r + CUM_W'(fv_r);

  assign dec_freq = FREQ_W'(slot_q_r.freq_m1) + FREQ_W'(1);
  assign s_hi     = lane_q_r[STATE_W-1:SCALE_BITS];
  assign t_val    = STATE_W'({p_up_r, {LO_W{1'b0}}}) + STATE_W'(p_lo_r)
                    + STATE_W'(ofs_r);
  assign take     = (t_val < RENORM_LOW);
  assign t_new    = take ? {t_val[WORD_W-1:0], word_r} : t_val;

  always_comb begin
    state_nxt     = state_r;
    cum_nxt       = cum_r;
    sym_idx_nxt   = sym_idx_r;
    lane_idx_nxt  = lane_idx_r;
    dec_lane_nxt  = dec_lane_r;
    tv_nxt        = tv_r;
    err_nxt       = err_r;
    at_low_nxt    = at_low_r;
    fill_j_nxt    = fill_j_r;
    fill_stop_nxt = fill_stop_r;
    fill_base_nxt = fill_base_r;
    fill_fm1_nxt  = fill_fm1_r;
    fill_sym_nxt  = fill_sym_r;
    res_sym_nxt   = res_sym_r;
    res_used_nxt  = res_used_r;
    slot_we       = 1'b0;
    slot_waddr    = fill_j_r[SCALE_BITS-1:0];
    slot_wdata    = '{freq_m1: fill_fm1_r, offset: fill_j_r[SCALE_BITS-1:0] - fill_base_r,
                      sym: fill_sym_r};
    lane_we       = 1'b0;
    lane_waddr    = dec_lane_r;
    lane_wdata    = t_new;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res_sym_nxt  = '0;
        res_used_nxt = 1'b0;
        state_nxt    = S_DONE;
        if (op_r == OP_BEGIN) begin
          cum_nxt      = '0;
          sym_idx_nxt  = '0;
          lane_idx_nxt = '0;
          dec_lane_nxt = '0;
          tv_nxt       = 1'b0;
          err_nxt      = ST_OK;
        end else if (err_r == ST_OK) begin
          case (op_r)
            OP_LOAD_FREQ: begin
              if (sym_idx_r < SYM_IDX_W'(SYMBOLS)) begin
                cum_nxt       = freq_end;
                sym_idx_nxt   = sym_idx_r + SYM_IDX_W'(1);
                if (sym_idx_r == SYM_IDX_W'(SYMBOLS - 1)) begin
                  tv_nxt = (freq_end == CUM_W'(M_TOTAL));
                  if (freq_end != CUM_W'(M_TOTAL)) err_nxt = ST_TABLE;
                end
                fill_j_nxt    = cum_r[SLOT_CNT_W-1:0];
                fill_stop_nxt = (freq_end >= CUM_W'(M_TOTAL)) ? SLOT_CNT_W'(M_TOTAL)
                                                               : freq_end[SLOT_CNT_W-1:0];
                fill_base_nxt = cum_r[SCALE_BITS-1:0];
                fill_fm1_nxt  = fv_r[SCALE_BITS-1:0] - SCALE_BITS'(1);
                fill_sym_nxt  = sym_idx_r[SYM_W-1:0];
                if ((cum_r < CUM_W'(M_TOTAL)) && (fv_r != '0)) state_nxt = S_FILL;
              end
            end
            OP_LOAD_LANE: begin
              if (lane_idx_r < LANE_CNT_W'(LANES)) begin
                lane_we    = 1'b1;
                lane_waddr = lane_idx_r[LANE_W-1:0];
                lane_wdata = ls_r;
                at_low_nxt[lane_idx_r[LANE_W-1:0]] = (ls_r == RENORM_LOW);
                lane_idx_nxt = lane_idx_r + LANE_CNT_W'(1);
              end
            end
            OP_DECODE: begin
              if (!lanes_ready) err_nxt = ST_TABLE;
              else state_nxt = S_SLOT;
            end
            OP_FINISH: begin
              if (!lanes_ready) err_nxt = ST_TABLE;
              else if (present_r || (at_low_r != '1)) err_nxt = ST_END;
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        slot_we    = 1'b1;
        fill_j_nxt = fill_j_r + SLOT_CNT_W'(1);
        if (fill_j_nxt >= fill_stop_r) state_nxt = S_DONE;
      end
      S_SLOT: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_DONE;
        if (take && !present_r) begin
          err_nxt = ST_SHORT;
        end else begin
          lane_we                 = 1'b1;
          at_low_nxt[dec_lane_r]  = (t_new == RENORM_LOW);
          res_sym_nxt             = ent_sym_r;
          res_used_nxt            = take;
          dec_lane_nxt = (dec_lane_r == LANE_W'(LANES - 1)) ? '0
                                                             : dec_lane_r + LANE_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cum_r       <= '0;
      sym_idx_r   <= '0;
      lane_idx_r  <= '0;
      dec_lane_r  <= '0;
      tv_r        <= 1'b0;
      err_r       <= ST_OK;
      at_low_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cum_r      <= cum_nxt;
      sym_idx_r  <= sym_idx_nxt;
      lane_idx_r <= lane_idx_nxt;
      dec_lane_r <= dec_lane_nxt;
      tv_r       <= tv_nxt;
      err_r      <= err_nxt;
      at_low_r   <= at_low_nxt;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    fill_j_r    <= fill_j_nxt;
    fill_stop_r <= fill_stop_nxt;
    fill_base_r <= fill_base_nxt;
    fill_fm1_r  <= fill_fm1_nxt;
    fill_sym_r  <= fill_sym_nxt;
    res_sym_r   <= res_sym_nxt;
    res_used_r  <= res_used_nxt;
    if (in_ch.valid && in_ch.ready) begin
      op_r      <= in_ch.op;
      fv_r      <= in_ch.freq_value;
      ls_r      <= in_ch.lane_state;
      word_r    <= in_ch.stream_word;
      present_r <= in_ch.word_present;
    end
    if (state_r == S_DONE && out_free) begin
      out_sym_r    <= res_sym_r;
      out_used_r   <= res_used_r;
      out_status_r <= err_r;
    end
  end

  // split 13x52 multiply, one register stage
  always_ff @(posedge clk) begin
    p_lo_r    <= dec_freq * s_hi[LO_W-1:0];
    p_up_r    <= dec_freq * s_hi[HI_W-1:LO_W];
    ofs_r     <= slot_q_r.offset;
    ent_sym_r <= slot_q_r.sym;
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_q_r <= slot_mem[lane_q_r[SCALE_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (lane_we) lane_mem[lane_waddr] <= lane_wdata;
    lane_q_r <= lane_mem[dec_lane_r];
  end

  `RID_ASSERT_IMP(a_fill_range, clk, rst_n, state_r == S_FILL, fill_j_r < fill_stop_r)
  `RID_ASSERT_NXT(a_accept_exec, clk, rst_n, in_ch.valid && in_ch.ready, state_r == S_EXEC)
  `RID_ASSERT_IMP(a_mul_ready, clk, rst_n, state_r == S_MUL, lanes_ready && err_r == ST_OK)
  `RID_ASSERT_NXT(a_sticky, clk, rst_n,
    state_r == S_EXEC && err_r != ST_OK && op_r != OP_BEGIN,
    $stable(err_r) && state_r == S_DONE)
  `RID_ASSERT_IMP(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_DONE)

endmodule
`default_nettype wire

// ===== test/rans_interleaved_decoder_tb.sv =====
// Testbench for the interleaved rANS decoder: encoded, broken and noisy frames against a scoreboard.
module rans_interleaved_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rid_pkg::*;

  localparam int unsigned ITEM_GOAL = 1950;
  localparam int OP_LAST = (1 << OP_W) - 1;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [FREQ_IN_W-1:0] freq_value;
    logic [STATE_W-1:0]   lane_state;
    logic [WORD_W-1:0]    stream_word;
    logic                 word_present;
  } in_word_t;

  typedef struct packed {
    logic [SYM_W-1:0]    symbol;
    logic                word_used;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef enum int {
    FRAME_CLEAN, FRAME_SHORT, FRAME_EXTRA_WORD, FRAME_BAD_LANE,
    FRAME_BAD_TOTAL, FRAME_EARLY, FRAME_NOISE
  } frame_kind_e;

  typedef enum int {TBL_SINGLE, TBL_UNIFORM, TBL_SKEWED} table_mode_e;

  class rans_scoreboard;
    slot_entry_t        slot_mem [M_TOTAL];
    logic [STATE_W-1:0] lane_mem [LANES];
    int unsigned        cum_total;
    int unsigned        sym_count;
    int unsigned        lane_count;
    int unsigned        next_lane;
    bit                 table_ok;
    logic [STATUS_W-1:0] err_code;
    result_t            due_results[$];
    int unsigned        mismatches;

    function new();
      cum_total  = 0;
      sym_count  = 0;
      lane_count = 0;
      next_lane  = 0;
      table_ok   = 1'b0;
      err_code   = ST_OK;
      mismatches = 0;
    endfunction

    function bit lanes_ready();
      return table_ok && lane_count >= LANES;
    endfunction

    // advance the decoder model by one accepted word, queue the result it owes
    function result_t note_word(in_word_t w);
      result_t            r;
      slot_entry_t        e;
      logic [STATE_W-1:0] s;
      logic [STATE_W-1:0] t;
      logic [STATE_W-1:0] f;
      bit                 take;
      bit                 bad;
      r = '0;
      if (w.op == OP_BEGIN) begin
        cum_total  = 0;
        sym_count  = 0;
        lane_count = 0;
        next_lane  = 0;
        table_ok   = 1'b0;
        err_code   = ST_OK;
      end else if (err_code == ST_OK) begin
        case (w.op)
          OP_LOAD_FREQ: begin
            if (sym_count < SYMBOLS) begin
              for (int unsigned j = cum_total; j < cum_total + w.freq_value && j < M_TOTAL;
                   j++) begin
                slot_mem[j] = '{freq_m1: SCALE_BITS'(w.freq_value - 1),
                                offset:  SCALE_BITS'(j - cum_total),
                                sym:     SYM_W'(sym_count)};
              end
              cum_total += w.freq_value;
              sym_count++;
              if (sym_count == SYMBOLS) begin
                table_ok = (cum_total == M_TOTAL);
                if (!table_ok) err_code = ST_TABLE;
              end
            end
          end
          OP_LOAD_LANE: begin
            if (lane_count < LANES) begin
              lane_mem[lane_count] = w.lane_state;
              lane_count++;
            end
          end
          OP_DECODE: begin
            if (!lanes_ready()) begin
              err_code = ST_TABLE;
            end else begin
              s = lane_mem[next_lane];
              e = slot_mem[s[SCALE_BITS-1:0]];
              f = STATE_W'(e.freq_m1) + 1;
              t = f * (s >> SCALE_BITS) + STATE_W'(e.offset);
              take = (t < RENORM_LOW);
              if (take && !w.word_present) begin
                err_code = ST_SHORT;
              end else begin
                if (take) t = {t[STATE_W-WORD_W-1:0], w.stream_word};
                lane_mem[next_lane] = t;
                r.symbol = e.sym;
                r.word_used = take;
                next_lane = (next_lane + 1) % LANES;
              end
            end
          end
          OP_FINISH: begin
            if (!lanes_ready()) begin
              err_code = ST_TABLE;
            end else begin
              bad = w.word_present;
              for (int k = 0; k < LANES; k++) begin
                if (lane_mem[k] != RENORM_LOW) bad = 1'b1;
              end
              if (bad) err_code = ST_END;
            end
          end
          default: ;
        endcase
      end
      r.status = err_code;
      due_results.push_back(r);
      return r;
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task check_word(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report("unexpected result word", 64'(got), 64'(0));
        return;
      end
      want = due_results.pop_front();
      if (got.symbol !== want.symbol) report("symbol", 64'(got.symbol), 64'(want.symbol));
      if (got.word_used !== want.word_used)
        report("word_used", 64'(got.word_used), 64'(want.word_used));
      if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit calm;
  int unsigned sent_items;
  rans_scoreboard sb = new();

  rans_in_if  in_ch();
  rans_out_if out_ch();

  rans_interleaved_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  function automatic int unsigned draw_wait();
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic in_word_t any_word(logic [OP_W-1:0] op);
    in_word_t w;
    w.op           = op;
    w.freq_value   = FREQ_IN_W'($urandom);
    w.lane_state   = {$urandom, $urandom};
    w.stream_word  = $urandom;
    w.word_present = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input bit counts, output bit used);
    int unsigned gap;
    result_t     r;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= w.op;
    in_ch.freq_value   <= w.freq_value;
    in_ch.lane_state   <= w.lane_state;
    in_ch.stream_word  <= w.stream_word;
    in_ch.word_present <= w.word_present;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = sb.note_word(w);
    used = r.word_used;
    if (counts) sent_items++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  task automatic run_frame(frame_kind_e kind, table_mode_e mode);
    int unsigned        freq_of [SYMBOLS];
    int unsigned        base_of [SYMBOLS];
    int unsigned        live[$];
    int unsigned        msg[$];
    logic [WORD_W-1:0]  words[$];
    logic [STATE_W-1:0] x [LANES];
    logic [STATE_W-1:0] cap;
    in_word_t           w;
    bit                 used;
    int unsigned        rem, c, n, ptr, fi, li, lane_odds, cut, sym, k, acc;

    drain_results();
    calm = ($urandom_range(0, 4) == 0);
    send_word(any_word(OP_BEGIN), 1'b1, used);

    if (kind == FRAME_NOISE) begin
      repeat ($urandom_range(10, 60)) begin
        w = any_word(($urandom_range(0, 9) == 0) ? OP_BEGIN : OP_W'($urandom_range(1, OP_LAST)));
        if ($urandom_range(0, 1)) w.freq_value = FREQ_IN_W'($urandom_range(0, 40));
        send_word(w, 1'b1, used);
      end
      return;
    end

    foreach (freq_of[s]) freq_of[s] = 0;
    case (mode)
      TBL_SINGLE:
        freq_of[$urandom_range(0, 1) ? SYMBOLS - 1 : $urandom_range(0, SYMBOLS - 1)] = M_TOTAL;
      TBL_UNIFORM:
        foreach (freq_of[s]) freq_of[s] = M_TOTAL / SYMBOLS;
      default: begin
        c = $urandom_range(1, SYMBOLS);
        foreach (freq_of[s]) if ($urandom_range(1, SYMBOLS) <= c) live.push_back(s);
        if (live.size() == 0) live.push_back($urandom_range(0, SYMBOLS - 1));
        foreach (live[i]) freq_of[live[i]] = 1;
        rem = M_TOTAL - live.size();
        while (rem > 0) begin
          c = $urandom_range(1, rem);
          freq_of[live[$urandom_range(0, live.size() - 1)]] += c;
          rem -= c;
        end
        live.delete();
      end
    endcase

    if (kind == FRAME_BAD_TOTAL) begin
      sym = $urandom_range(0, SYMBOLS - 1);
      case ($urandom_range(0, 2))
        0: freq_of[sym] = (1 << FREQ_IN_W) - 1;
        1: freq_of[sym] = (freq_of[sym] > 0) ? freq_of[sym] - 1 : freq_of[sym] + 1;
        default: freq_of[sym] += $urandom_range(1, M_TOTAL);
      endcase
    end

    acc = 0;
    foreach (freq_of[s]) begin
      base_of[s] = acc;
      acc += freq_of[s];
      if (freq_of[s] > 0) live.push_back(s);
    end

    // encode a random message backwards so the decoder ends with every lane at 2^31
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2 * LANES)
                                    : $urandom_range(2 * LANES + 1, 160);
    for (int i = 0; i < n; i++) msg.push_back(live[$urandom_range(0, live.size() - 1)]);
    foreach (x[j]) x[j] = RENORM_LOW;
    for (int i = n - 1; i >= 0; i--) begin
      k = i % LANES;
      sym = msg[i];
      cap = ((RENORM_LOW >> SCALE_BITS) << WORD_W) * STATE_W'(freq_of[sym]);
      if (x[k] >= cap) begin
        words.push_front(x[k][WORD_W-1:0]);
        x[k] = x[k] >> WORD_W;
      end
      x[k] = ((x[k] / freq_of[sym]) << SCALE_BITS) + (x[k] % freq_of[sym]) + base_of[sym];
    end

    case (kind)
      FRAME_SHORT:
        repeat ($urandom_range(1, 3)) if (words.size() > 0) void'(words.pop_back());
      FRAME_EXTRA_WORD:
        words.push_back($urandom);
      FRAME_BAD_LANE: begin
        k = $urandom_range(0, LANES - 1);
        x[k] = $urandom_range(0, 1) ? {$urandom, $urandom}
                                    : x[k] ^ (STATE_W'(1) << $urandom_range(0, STATE_W - 1));
      end
      default: ;
    endcase

    // lane loads go first, last, or sprinkled among the frequency words
    case ($urandom_range(0, 2))
      0: lane_odds = 0;
      1: lane_odds = 1;
      default: lane_odds = 40;
    endcase
    cut = (kind == FRAME_EARLY) ? $urandom_range(0, SYMBOLS + LANES - 1) : SYMBOLS + LANES;
    fi = 0;
    li = 0;
    while ((fi < SYMBOLS || li < LANES) && fi + li < cut) begin
      if (li < LANES && (fi == SYMBOLS || (lane_odds > 0 && $urandom_range(1, lane_odds) == 1)))
      begin
        w = any_word(OP_LOAD_LANE);
        w.lane_state = x[li];
        li++;
      end else begin
        w = any_word(OP_LOAD_FREQ);
        w.freq_value = FREQ_IN_W'(freq_of[fi]);
        fi++;
      end
      send_word(w, 1'b1, used);
      if ($urandom_range(0, 63) == 0)
        send_word(any_word(OP_W'($urandom_range(OP_FINISH + 1, OP_LAST))), 1'b0, used);
    end

    if (kind == FRAME_EARLY) begin
      send_word(any_word($urandom_range(0, 1) ? OP_DECODE : OP_FINISH), 1'b1, used);
      repeat ($urandom_range(0, 3))
        send_word(any_word(OP_W'($urandom_range(OP_LOAD_FREQ, OP_FINISH))), 1'b1, used);
      return;
    end

    if ($urandom_range(0, 3) == 0) send_word(any_word(OP_LOAD_FREQ), 1'b0, used);
    if ($urandom_range(0, 3) == 0) send_word(any_word(OP_LOAD_LANE), 1'b0, used);

    ptr = 0;
    for (int i = 0; i < n; i++) begin
      w = any_word(OP_DECODE);
      w.word_present = (ptr < words.size());
      if (w.word_present) w.stream_word = words[ptr];
      send_word(w, 1'b1, used);
      if (used) ptr++;
      if ($urandom_range(0, 31) == 0)
        send_word(any_word(OP_W'($urandom_range(OP_FINISH + 1, OP_LAST))), 1'b0, used);
    end

    w = any_word(OP_FINISH);
    w.word_present = (ptr < words.size());
    if (w.word_present) w.stream_word = words[ptr];
    send_word(w, 1'b1, used);
    if ($urandom_range(0, 7) == 0) send_word(any_word(OP_DECODE), 1'b1, used);
  endtask

  initial begin : result_sink
    int unsigned stall;
    result_t     got;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.symbol    = out_ch.symbol;
      got.word_used = out_ch.word_used;
      got.status    = out_ch.status;
      sb.check_word(got);
    end
  end

  initial begin : word_source
    in_word_t    w;
    bit          used;
    int unsigned pick;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_BEGIN;
    in_ch.freq_value   = '0;
    in_ch.lane_state   = '0;
    in_ch.stream_word  = '0;
    in_ch.word_present = 1'b0;
    sent_items         = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: early decode/finish, unused opcodes, held errors, field extremes
    send_word(any_word(OP_DECODE), 1'b1, used);
    send_word(any_word(OP_W'(OP_FINISH + 1)), 1'b0, used);
    send_word(any_word(OP_BEGIN), 1'b1, used);
    for (int op = OP_FINISH + 1; op <= OP_LAST; op++) send_word(any_word(OP_W'(op)), 1'b0, used);
    send_word(any_word(OP_FINISH), 1'b1, used);
    send_word(any_word(OP_BEGIN), 1'b1, used);
    w = any_word(OP_LOAD_LANE);
    w.lane_state = '0;
    send_word(w, 1'b1, used);
    w.lane_state = '1;
    send_word(w, 1'b1, used);
    w.lane_state = RENORM_LOW;
    send_word(w, 1'b1, used);
    send_word(any_word(OP_DECODE), 1'b1, used);
    send_word(any_word(OP_BEGIN), 1'b1, used);
    w = any_word(OP_LOAD_FREQ);
    w.freq_value = '1;
    send_word(w, 1'b1, used);
    w.freq_value = '0;
    send_word(w, 1'b1, used);
    w = any_word(OP_FINISH);
    w.word_present = 1'b0;
    send_word(w, 1'b1, used);

    run_frame(FRAME_CLEAN, TBL_SINGLE);
    run_frame(FRAME_CLEAN, TBL_UNIFORM);
    run_frame(FRAME_BAD_TOTAL, TBL_SKEWED);
    run_frame(FRAME_EARLY, TBL_SKEWED);
    run_frame(FRAME_NOISE, TBL_SKEWED);

    while (sent_items < ITEM_GOAL) begin
      pick = $urandom_range(0, 11);
      run_frame((pick < 5) ? FRAME_CLEAN :
                (pick == 5) ? FRAME_SHORT :
                (pick == 6) ? FRAME_EXTRA_WORD :
                (pick == 7) ? FRAME_BAD_LANE :
                (pick == 8) ? FRAME_BAD_TOTAL :
                (pick == 9) ? FRAME_EARLY : FRAME_NOISE,
                ($urandom_range(0, 5) == 0) ? TBL_SINGLE :
                ($urandom_range(0, 4) == 0) ? TBL_UNIFORM : TBL_SKEWED);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== rans_interleaved_decoder.f =====
+incdir+rtl
rtl/rid_pkg.sv
rtl/rans_if.sv
rtl/rans_interleaved_decoder.sv
test/rans_interleaved_decoder_tb.sv
